FILE: rtl/pra_pkg.sv
// Shared types and constants for the protection region allocator.
`default_nettype none
package pra_pkg;
  localparam int REGION_SLOTS_DEF = 16;
  localparam int HW_ENTRIES_DEF = 16;
  localparam int PAGE_BYTES_DEF = 4096;

  localparam logic [7:0] MODE_TOR = 8'h08;
  localparam logic [7:0] MODE_NAPOT = 8'h18;

  typedef enum logic [2:0] {
    ACT_ALLOC = 3'd0,
    ACT_FREE = 3'd1,
    ACT_ENC_SET = 3'd2,
    ACT_ENC_UNSET = 3'd3,
    ACT_QUERY = 3'd4,
    ACT_CHECK = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_BAD_SIZE = 3'd1,
    ST_OVERLAP = 3'd2,
    ST_UNALIGNED = 3'd3,
    ST_BAD_TOR = 3'd4,
    ST_NO_ROOM = 3'd5,
    ST_BAD_SLOT = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PRI_ANY = 2'd0,
    PRI_TOP = 2'd1,
    PRI_BOTTOM = 2'd2
  } pri_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_EXEC,
    S_OUT1,
    S_OUT2
  } fsm_t;

  // Region record as held in the table memory.
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] size;
    logic is_tor;
    logic may_overlap;
    logic [4:0] entry;
  } region_t;

  localparam int REC_W = $bits(region_t);
endpackage
`default_nettype wire

FILE: rtl/pra_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module pra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/pmp_region_allocator_core.sv
// Top level of the protection region allocator: table memory and sequencer.
`default_nettype none
//
//  channel | direction | handshake     | payload
//  --------+-----------+---------------+-----------------------------------------
//  in      | sink      | valid / stall | action, region_start ... permission
//  out     | source    | out_valid /   | status, slot_given, entry_index, ...,
//          |           | out_stall     | overlap_found, last
//
//  One item at a time. Allocate and check_overlap scan every region slot
//  through the table memory, one read a cycle.
//  Free, encode and query read one record each.
//  Encode of a two-entry TOR region gives two beats.
//  Reset clears the slot and entry maps; records of free slots are never used
//  because the slot map gates every read result, so the table needs no clearing pass.
//  Output stalls hold the beat; input stall stays high until the item is done.
module pmp_region_allocator_core
  import pra_pkg::*;
#(
  parameter int REGION_SLOTS = REGION_SLOTS_DEF,
  parameter int HW_ENTRIES = HW_ENTRIES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic valid,
  output logic stall,
  input wire logic [2:0] action,
  input wire logic [63:0] region_start,
  input wire logic [63:0] region_length,
  input wire logic [1:0] priority_req,
  input wire logic overlap_allowed,
  input wire logic [3:0] slot,
  input wire logic [2:0] permission,
  output logic out_valid,
  input wire logic out_stall,
  output logic [2:0] status,
  output logic [3:0] slot_given,
  output logic [3:0] entry_index,
  output logic [63:0] entry_address,
  output logic [7:0] entry_config,
  output logic [63:0] base_out,
  output logic [63:0] length_out,
  output logic overlap_found,
  output logic last
);
  localparam int SW = $clog2(REGION_SLOTS);
  localparam int EW = $clog2(HW_ENTRIES);
  localparam logic [63:0] PG_MASK = 64'(PAGE_BYTES - 1);

  fsm_t state, state_next;

  // Latched request.
  logic [2:0] act;
  logic [63:0] req_start, req_len;
  logic [1:0] req_pri;
  logic req_allow;
  logic [3:0] req_slot;
  logic [2:0] req_perm;

  logic [REGION_SLOTS-1:0] slot_map;
  logic [HW_ENTRIES-1:0] entry_map;

  logic [SW-1:0] scan_idx;
  logic scan_rd_valid;
  logic [SW-1:0] scan_rd_idx;
  logic hit;

  // Table memory.
  logic ram_we;
  logic [SW-1:0] ram_waddr, ram_raddr;
  region_t ram_wdata, rec;

  pra_ram #(.WIDTH(REC_W), .DEPTH(REGION_SLOTS)) u_table (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(rec)
  );

  logic accept_in;
  assign stall = (state != S_IDLE);
  assign accept_in = valid && !stall;

  logic slot_ok;
  assign slot_ok = ({1'b0, req_slot} < 5'(REGION_SLOTS)) && slot_map[req_slot[SW-1:0]];

  // Overlap test of the scanned record against the request.
  logic [63:0] req_end, rec_end;
  logic req_wrap, rec_hits;
  assign req_end = req_start + req_len;
  assign req_wrap = req_end < req_start;
  assign rec_end = rec.base + rec.size;
  assign rec_hits = slot_map[scan_rd_idx] && !rec.may_overlap &&
                    (rec.base < req_end) && (rec_end > req_start);

  // Free slot and entry search (lowest index).
  logic free_slot_found;
  logic [SW-1:0] free_slot;
  logic e1_found, e2_found;
  logic [EW-1:0] e1, e2;
  always_comb begin
    free_slot_found = 1'b0;
    free_slot = '0;
    for (int i = REGION_SLOTS - 1; i >= 0; i--) begin
      if (!slot_map[i]) begin
        free_slot_found = 1'b1;
        free_slot = SW'(i);
      end
    end
    e1_found = 1'b0;
    e1 = '0;
    for (int i = HW_ENTRIES - 1; i >= 0; i--) begin
      if (!entry_map[i]) begin
        e1_found = 1'b1;
        e1 = EW'(i);
      end
    end
    e2_found = 1'b0;
    e2 = '0;
    for (int i = HW_ENTRIES - 2; i >= 0; i--) begin
      if (!entry_map[i] && !entry_map[i+1]) begin
        e2_found = 1'b1;
        e2 = EW'(i);
      end
    end
  end

  // Allocate decision (valid in S_EXEC).
  logic pri_any, pri_top, is_napot;
  logic [2:0] alloc_st;
  logic [EW-1:0] alloc_entry;
  logic [HW_ENTRIES-1:0] alloc_emask;
  always_comb begin
    pri_any = (req_pri == PRI_ANY) || (req_pri == 2'd3);
    pri_top = (req_pri == PRI_TOP);
    is_napot = (req_len == '1 && req_start == '0) ||
               (((req_len & (req_len - 64'd1)) == '0) &&
                ((req_start & (req_len - 64'd1)) == '0));
    alloc_entry = '0;
    alloc_emask = '0;
    alloc_st = ST_OK;
    if (req_len == '0) begin
      alloc_st = ST_BAD_SIZE;
    end else if (!req_allow && (req_wrap || hit)) begin
      alloc_st = ST_OVERLAP;
    end else if ((req_len != '1 && (req_len & PG_MASK) != '0) ||
                 (req_start & PG_MASK) != '0) begin
      alloc_st = ST_UNALIGNED;
    end else if (!is_napot && !pri_any && !(pri_top && req_start == '0)) begin
      alloc_st = ST_BAD_TOR;
    end else if (!free_slot_found) begin
      alloc_st = ST_NO_ROOM;
    end else if (is_napot) begin
      if (pri_any) begin
        if (!e1_found) alloc_st = ST_NO_ROOM;
        alloc_entry = e1;
        alloc_emask[e1] = 1'b1;
      end else if (pri_top) begin
        if (entry_map[0]) alloc_st = ST_NO_ROOM;
        alloc_emask[0] = 1'b1;
      end else begin
        alloc_entry = EW'(HW_ENTRIES - 1);
        alloc_emask[HW_ENTRIES-1] = 1'b1;
      end
    end else if (pri_any) begin
      if (!e2_found) alloc_st = ST_NO_ROOM;
      alloc_entry = e2 + EW'(1);
      alloc_emask[e2] = 1'b1;
      alloc_emask[e2+EW'(1)] = 1'b1;
    end else begin
      if (entry_map[0]) alloc_st = ST_NO_ROOM;
      alloc_emask[0] = 1'b1;
    end
  end

  // Record view for free / encode / query.
  logic two;
  logic [4:0] lo_entry;
  logic [63:0] enc_addr;
  assign two = rec.is_tor && (rec.entry != '0);
  assign lo_entry = rec.entry - 5'd1;
  always_comb begin
    if (rec.base == '0 && rec.size == '1) begin
      enc_addr = '1;
    end else if (!rec.is_tor) begin
      enc_addr = (rec.base | ((rec.size >> 1) - 64'd1)) >> 2;
    end else begin
      enc_addr = rec_end >> 2;
    end
  end

  // First result beat and map updates of the item, taken in S_EXEC.
  logic [2:0] res_status;
  logic [3:0] res_slot, res_entry;
  logic [63:0] res_addr, res_base, res_len;
  logic [7:0] res_cfg;
  logic res_ovl, res_last;
  logic [REGION_SLOTS-1:0] slot_map_next;
  logic [HW_ENTRIES-1:0] entry_map_next;
  always_comb begin
    res_status = ST_OK;
    res_slot = '0;
    res_entry = '0;
    res_addr = '0;
    res_cfg = '0;
    res_base = '0;
    res_len = '0;
    res_ovl = 1'b0;
    res_last = 1'b1;
    slot_map_next = slot_map;
    entry_map_next = entry_map;
    case (act)
      ACT_ALLOC: begin
        res_status = alloc_st;
        if (alloc_st == ST_OK) begin
          res_slot = 4'(free_slot);
          slot_map_next[free_slot] = 1'b1;
          entry_map_next = entry_map | alloc_emask;
        end
      end
      ACT_CHECK: res_ovl = req_wrap || hit;
      ACT_QUERY: begin
        if (!slot_ok) res_status = ST_BAD_SLOT;
        else begin
          res_base = rec.base;
          res_len = rec.size;
        end
      end
      ACT_FREE: begin
        if (!slot_ok) res_status = ST_BAD_SLOT;
        else begin
          slot_map_next[req_slot[SW-1:0]] = 1'b0;
          entry_map_next[rec.entry[EW-1:0]] = 1'b0;
          if (two) entry_map_next[lo_entry[EW-1:0]] = 1'b0;
        end
      end
      default: begin
        if (!slot_ok) res_status = ST_BAD_SLOT;
        else begin
          res_entry = rec.entry[3:0];
          res_last = !two;
          if (act == ACT_ENC_SET) begin
            res_addr = enc_addr;
            res_cfg = (rec.is_tor ? MODE_TOR : MODE_NAPOT) | {5'd0, req_perm};
          end
        end
      end
    endcase
  end

  // Sequencer. Hold the read address on the request slot outside the scan so
  // the record stays valid through both output beats.
  always_comb begin
    state_next = state;
    ram_raddr = req_slot[SW-1:0];
    case (state)
      S_IDLE: if (accept_in) begin
        state_next = (action == ACT_ALLOC || action == ACT_CHECK) ? S_SCAN : S_READ;
        if (action > ACT_CHECK) state_next = S_IDLE;
      end
      S_SCAN: begin
        ram_raddr = scan_idx;
        if (scan_idx == SW'(REGION_SLOTS - 1)) state_next = S_READ;
      end
      S_READ: state_next = S_EXEC;
      S_EXEC: state_next = S_OUT1;
      S_OUT1: if (!out_stall) state_next = (out_valid && !last) ? S_OUT2 : S_IDLE;
      S_OUT2: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign ram_we = (state == S_EXEC) && (act == ACT_ALLOC) && (alloc_st == ST_OK);
  assign ram_waddr = free_slot;
  always_comb begin
    ram_wdata.base = req_start;
    ram_wdata.size = req_len;
    ram_wdata.is_tor = !is_napot;
    ram_wdata.may_overlap = req_allow;
    ram_wdata.entry = 5'(alloc_entry);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot_map <= '0;
      entry_map <= '0;
      out_valid <= 1'b0;
      scan_rd_valid <= 1'b0;
      hit <= 1'b0;
    end else begin
      state <= state_next;
      scan_rd_valid <= (state == S_SCAN);
      scan_rd_idx <= scan_idx;
      if (scan_rd_valid && rec_hits) hit <= 1'b1;
      case (state)
        S_IDLE: begin
          hit <= 1'b0;
          scan_idx <= '0;
          if (accept_in) begin
            act <= action;
            req_start <= region_start;
            req_len <= region_length;
            req_pri <= priority_req;
            req_allow <= overlap_allowed;
            req_slot <= slot;
            req_perm <= permission;
          end
        end
        S_SCAN: scan_idx <= scan_idx + SW'(1);
        S_EXEC: begin
          out_valid <= 1'b1;
          status <= res_status;
          slot_given <= res_slot;
          entry_index <= res_entry;
          entry_address <= res_addr;
          entry_config <= res_cfg;
          base_out <= res_base;
          length_out <= res_len;
          overlap_found <= res_ovl;
          last <= res_last;
          slot_map <= slot_map_next;
          entry_map <= entry_map_next;
        end
        S_OUT1: if (!out_stall) begin
          if (!last) begin
            entry_index <= lo_entry[3:0];
            entry_address <= (act == ACT_ENC_SET) ? (rec.base >> 2) : '0;
            entry_config <= '0;
            last <= 1'b1;
          end else begin
            out_valid <= 1'b0;
          end
        end
        S_OUT2: if (!out_stall) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
